FILE: rtl/tcd_pkg.sv
package tcd_pkg;

  localparam logic signed [47:0] POS_MAX48 = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] NEG_MIN48 = 48'sh8000_0000_0000;
  localparam logic [48:0]        ONE_Q16   = 49'h0_0000_0001_0000;
  localparam logic [48:0]        RATIO_CAP = 49'h1_0000_0000_0000;

  localparam logic [1:0] KIND_CHAIN    = 2'd0;
  localparam logic [1:0] KIND_INTEGRAL = 2'd1;
  localparam logic [1:0] KIND_POWER    = 2'd2;

  typedef enum logic [1:0] {
    REG_TARGET = 2'd0,
    REG_TAU    = 2'd1,
    REG_COUNT  = 2'd2,
    REG_EXCL   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [47:0] target_energy_per_dof;
    logic [31:0] inv_relax_time_sq;
    logic [3:0]  chain_count;
    logic [2:0]  excluded_dofs;
  } cfg_regs_t;

  typedef struct packed {
    logic [47:0]        kinetic_energy;
    logic [11:0]        mobility_count;
    logic [11:0]        constraint_count;
    logic signed [31:0] chain_value;
  } in_item_t;

  typedef struct packed {
    logic signed [47:0] deriv_value;
    logic [1:0]         deriv_kind;
    logic [2:0]         deriv_index;
    logic               last_of_run;
  } out_item_t;

  typedef struct packed {
    logic        start;
    logic [47:0] a;
    logic [47:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [95:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [59:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [47:0] quo;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEN,
    ST_DIV,
    ST_RATE,
    ST_RED,
    ST_SQ,
    ST_TERM,
    ST_PWR,
    ST_EMIT_CPREV,
    ST_EMIT_IPREV,
    ST_EMIT_CCUR,
    ST_EMIT_ICUR,
    ST_EMIT_PWR
  } seq_state_t;

endpackage

FILE: rtl/tcd_mul.sv
module tcd_mul
  import tcd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic [47:0] a_r;
  logic [47:0] b_r;
  logic [95:0] acc_r;
  logic [1:0]  dig_r;
  logic        run_r;
  logic        done_r;
  logic [15:0] b_dig;
  logic [63:0] pp;
  logic [95:0] pp_sh;

  // one 16-bit digit of b per cycle
  always_comb begin
    unique case (dig_r)
      2'd0:    b_dig = b_r[15:0];
      2'd1:    b_dig = b_r[31:16];
      2'd2:    b_dig = b_r[47:32];
      default: b_dig = '0;
    endcase
  end

  assign pp = {16'b0, a_r} * {48'b0, b_dig};

  always_comb begin
    unique case (dig_r)
      2'd0:    pp_sh = {32'b0, pp};
      2'd1:    pp_sh = {16'b0, pp, 16'b0};
      2'd2:    pp_sh = {pp, 32'b0};
      default: pp_sh = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      dig_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        dig_r <= '0;
      end else if (run_r) begin
        dig_r <= dig_r + 2'd1;
        if (dig_r == 2'd2) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= req.a;
      b_r   <= req.b;
      acc_r <= '0;
    end else if (run_r) begin
      acc_r <= acc_r + pp_sh;
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

FILE: rtl/tcd_div.sv
module tcd_div
  import tcd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int unsigned QBITS = 48;
  localparam logic [5:0]  LAST_STEP = 6'(QBITS - 1);

  logic [59:0] rem_r;
  logic [59:0] den_r;
  logic [47:0] nb_r;
  logic [5:0]  cnt_r;
  logic        run_r;
  logic        done_r;
  logic [60:0] trial;
  logic [60:0] diff;
  logic        ge;

  // restoring step: numerator bits shift out of nb_r, quotient bits shift in
  assign trial = {rem_r, nb_r[47]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == LAST_STEP) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= {44'b0, req.num[63:48]};
      nb_r  <= req.num[47:0];
      den_r <= req.den;
    end else if (run_r) begin
      rem_r <= ge ? diff[59:0] : trial[59:0];
      nb_r  <= {nb_r[46:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = nb_r;

endmodule

FILE: rtl/tcd_seq.sv
module tcd_seq
  import tcd_pkg::*;
#(
  parameter int MAX_CHAINS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_regs_t cfg,
  input  logic      in_valid,
  input  in_item_t  in_data,
  output logic      in_ready,
  output logic      emit_valid,
  input  logic      emit_ready,
  output out_item_t emit_item,
  output mul_req_t  mul_req,
  input  mul_rsp_t  mul_rsp,
  output div_req_t  div_req,
  input  div_rsp_t  div_rsp
);

  localparam int         PW       = (MAX_CHAINS > 1) ? $clog2(MAX_CHAINS) : 1;
  localparam logic [4:0] MAX_CNT  = 5'(MAX_CHAINS);
  localparam logic signed [59:0] POS_LIM = 60'sd140737488355327;
  localparam logic signed [59:0] NEG_LIM = -60'sd140737488355328;

  seq_state_t state_r, state_nxt;
  logic          issued_r, issued_nxt;
  logic [PW-1:0] position_r, position_nxt;

  logic [PW-1:0]      cur_pos_r;
  logic               is_last_r;
  logic signed [31:0] z_r;
  logic signed [31:0] prev_r;
  logic signed [31:0] first_r;
  logic [47:0]        held_energy_r;
  logic [11:0]        held_dof_r;
  logic [48:0]        ratio_r;
  logic signed [47:0] pending_r;
  logic signed [47:0] chain_prev_r;
  logic [47:0]        sq_r;
  logic signed [47:0] power_r;

  logic [4:0]         m_eff;
  logic [PW-1:0]      pos_eff;
  logic               accept;
  logic               last_now;
  logic signed [13:0] nd_raw;
  logic [11:0]        nd;
  logic               ratio_cap;
  logic               d_neg;
  logic [47:0]        d_mag;
  logic [31:0]        prev_mag;
  logic [31:0]        z_mag;
  logic [31:0]        first_mag;
  logic               red_neg;
  logic               pwr_neg;
  logic [47:0]        nk;
  logic [4:0]         pos5;
  logic [4:0]         pos5m1;
  logic signed [47:0] red_val;
  logic signed [59:0] chain_diff;
  logic signed [59:0] term_diff;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(~v + 32'sd1) : 32'(v);
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [59:0] v);
    logic signed [47:0] r;
    if (v > POS_LIM) r = POS_MAX48;
    else if (v < NEG_LIM) r = NEG_MIN48;
    else r = v[47:0];
    return r;
  endfunction

  // drop 16 fraction bits of the magnitude, apply sign, saturate
  function automatic logic signed [47:0] q16_sat(input logic [95:0] p, input logic neg);
    logic signed [47:0] mv;
    logic signed [47:0] r;
    mv = {1'b0, p[62:16]};
    if (|p[95:63]) r = neg ? NEG_MIN48 : POS_MAX48;
    else r = neg ? -mv : mv;
    return r;
  endfunction

  always_comb begin
    if (cfg.chain_count == 4'd0) m_eff = 5'd1;
    else if ({1'b0, cfg.chain_count} > MAX_CNT) m_eff = MAX_CNT;
    else m_eff = {1'b0, cfg.chain_count};
  end

  assign pos_eff  = (5'(position_r) >= m_eff) ? '0 : position_r;
  assign last_now = 5'(pos_eff) == (m_eff - 5'd1);
  assign accept   = in_valid && in_ready;

  assign nd_raw = $signed({2'b0, in_data.mobility_count})
                - $signed({2'b0, in_data.constraint_count})
                - $signed({11'b0, cfg.excluded_dofs});
  assign nd     = (nd_raw < 14'sd1) ? 12'd1 : nd_raw[11:0];

  assign ratio_cap = (mul_rsp.prod[59:16] == '0)
                  && (held_energy_r[47:32] >= mul_rsp.prod[15:0]);

  assign d_neg = ratio_r < ONE_Q16;
  assign d_mag = d_neg ? 48'(ONE_Q16 - ratio_r) : 48'(ratio_r - ONE_Q16);

  assign prev_mag  = mag32(prev_r);
  assign z_mag     = mag32(z_r);
  assign first_mag = mag32(first_r);
  assign red_neg   = prev_r[31] ^ z_r[31];
  assign pwr_neg   = !first_r[31] && (first_r != 32'sd0);
  assign nk        = (cur_pos_r == PW'(1)) ? 48'(held_dof_r) : 48'd1;

  assign pos5   = 5'(cur_pos_r);
  assign pos5m1 = pos5 - 5'd1;

  assign red_val    = q16_sat(mul_rsp.prod, red_neg);
  assign chain_diff = 60'(pending_r) - 60'(red_val);
  assign term_diff  = $signed({1'b0, mul_rsp.prod[58:0]})
                    - $signed({28'b0, cfg.inv_relax_time_sq});

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:       if (accept) state_nxt = (pos_eff == '0) ? ST_DEN : ST_RED;
      ST_DEN:        if (mul_rsp.done) state_nxt = ratio_cap ? ST_RATE : ST_DIV;
      ST_DIV:        if (div_rsp.done) state_nxt = ST_RATE;
      ST_RATE:       if (mul_rsp.done) state_nxt = is_last_r ? ST_PWR : ST_IDLE;
      ST_RED:        if (mul_rsp.done) state_nxt = ST_SQ;
      ST_SQ:         if (mul_rsp.done) state_nxt = ST_TERM;
      ST_TERM:       if (mul_rsp.done) state_nxt = ST_EMIT_CPREV;
      ST_PWR:        if (mul_rsp.done) state_nxt = ST_EMIT_CCUR;
      ST_EMIT_CPREV: if (emit_ready) state_nxt = ST_EMIT_IPREV;
      ST_EMIT_IPREV: if (emit_ready) state_nxt = is_last_r ? ST_PWR : ST_IDLE;
      ST_EMIT_CCUR:  if (emit_ready) state_nxt = ST_EMIT_ICUR;
      ST_EMIT_ICUR:  if (emit_ready) state_nxt = ST_EMIT_PWR;
      ST_EMIT_PWR:   if (emit_ready) state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    issued_nxt = issued_r;
    if (mul_rsp.done) issued_nxt = 1'b0;
    else if (mul_req.start) issued_nxt = 1'b1;
    position_nxt = position_r;
    if (accept) position_nxt = last_now ? '0 : pos_eff + PW'(1);
  end

  // outputs
  always_comb begin
    in_ready   = 1'b0;
    mul_req    = '0;
    div_req    = '0;
    emit_valid = 1'b0;
    emit_item  = '0;
    unique case (state_r)
      ST_IDLE: in_ready = rst_n;
      ST_DEN: begin
        mul_req.start = !issued_r;
        mul_req.a     = cfg.target_energy_per_dof;
        mul_req.b     = 48'(held_dof_r);
        div_req.start = mul_rsp.done && !ratio_cap;
        div_req.num   = {held_energy_r, 16'b0};
        div_req.den   = mul_rsp.prod[59:0];
      end
      ST_DIV: ;
      ST_RATE: begin
        mul_req.start = !issued_r;
        mul_req.a     = d_mag;
        mul_req.b     = 48'(cfg.inv_relax_time_sq);
      end
      ST_RED: begin
        mul_req.start = !issued_r;
        mul_req.a     = 48'(prev_mag);
        mul_req.b     = 48'(z_mag);
      end
      ST_SQ: begin
        mul_req.start = !issued_r;
        mul_req.a     = 48'(prev_mag);
        mul_req.b     = 48'(prev_mag);
      end
      ST_TERM: begin
        mul_req.start = !issued_r;
        mul_req.a     = sq_r;
        mul_req.b     = nk;
      end
      ST_PWR: begin
        mul_req.start = !issued_r;
        mul_req.a     = {15'b0, first_mag, 1'b0};
        mul_req.b     = held_energy_r;
      end
      ST_EMIT_CPREV: begin
        emit_valid            = 1'b1;
        emit_item.deriv_value = chain_prev_r;
        emit_item.deriv_kind  = KIND_CHAIN;
        emit_item.deriv_index = pos5m1[2:0];
      end
      ST_EMIT_IPREV: begin
        emit_valid            = 1'b1;
        emit_item.deriv_value = {{16{prev_r[31]}}, prev_r};
        emit_item.deriv_kind  = KIND_INTEGRAL;
        emit_item.deriv_index = pos5m1[2:0];
      end
      ST_EMIT_CCUR: begin
        emit_valid            = 1'b1;
        emit_item.deriv_value = pending_r;
        emit_item.deriv_kind  = KIND_CHAIN;
        emit_item.deriv_index = pos5[2:0];
      end
      ST_EMIT_ICUR: begin
        emit_valid            = 1'b1;
        emit_item.deriv_value = {{16{z_r[31]}}, z_r};
        emit_item.deriv_kind  = KIND_INTEGRAL;
        emit_item.deriv_index = pos5[2:0];
      end
      ST_EMIT_PWR: begin
        emit_valid            = 1'b1;
        emit_item.deriv_value = power_r;
        emit_item.deriv_kind  = KIND_POWER;
        emit_item.last_of_run = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      issued_r   <= 1'b0;
      position_r <= '0;
    end else begin
      state_r    <= state_nxt;
      issued_r   <= issued_nxt;
      position_r <= position_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      z_r       <= in_data.chain_value;
      cur_pos_r <= pos_eff;
      is_last_r <= last_now;
      if (pos_eff == '0) begin
        held_energy_r <= in_data.kinetic_energy;
        held_dof_r    <= nd;
        first_r       <= in_data.chain_value;
      end
    end
    if (state_r == ST_DEN && mul_rsp.done && ratio_cap) ratio_r <= RATIO_CAP;
    if (state_r == ST_DIV && div_rsp.done) ratio_r <= {1'b0, div_rsp.quo};
    if (state_r == ST_RATE && mul_rsp.done) pending_r <= q16_sat(mul_rsp.prod, d_neg);
    if (state_r == ST_RED && mul_rsp.done) chain_prev_r <= sat48(chain_diff);
    if (state_r == ST_SQ && mul_rsp.done) sq_r <= mul_rsp.prod[63:16];
    if (state_r == ST_TERM && mul_rsp.done) pending_r <= sat48(term_diff);
    if (state_r == ST_PWR && mul_rsp.done) power_r <= q16_sat(mul_rsp.prod, pwr_neg);
    if (state_r != ST_IDLE && state_nxt == ST_IDLE) prev_r <= z_r;
  end

endmodule

FILE: rtl/thermostat_chain_derivatives.sv
// item 0 takes a product, a 48-step restoring divide (skipped when the ratio caps)
//   and a product; later items take three products and two result transfers
// the last item of a run adds a power product and three result transfers
// one item at a time: the next item is taken once the sequencer is idle again and the
//   last result, if any, is in the output register; all products share the 48x16 multiplier
// reset: synchronous active low, config registers return to defaults, chain position to 0
module thermostat_chain_derivatives
  import tcd_pkg::*;
#(
  parameter int MAX_CHAINS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  cfg_reg_t    cfg_index,
  input  logic [47:0] cfg_data
);

  cfg_regs_t cfg_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  logic      emit_valid;
  logic      emit_ready;
  out_item_t emit_item;
  mul_req_t  mul_req;
  mul_rsp_t  mul_rsp;
  div_req_t  div_req;
  div_rsp_t  div_rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_energy_per_dof <= 48'd65536;
      cfg_r.inv_relax_time_sq     <= 32'd65536;
      cfg_r.chain_count           <= 4'd3;
      cfg_r.excluded_dofs         <= 3'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TARGET: cfg_r.target_energy_per_dof <= cfg_data;
        REG_TAU:    cfg_r.inv_relax_time_sq     <= cfg_data[31:0];
        REG_COUNT:  cfg_r.chain_count           <= cfg_data[3:0];
        REG_EXCL:   cfg_r.excluded_dofs         <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // output register
  assign emit_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_valid && emit_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_valid && emit_ready) out_data_r <= emit_item;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  tcd_seq #(
    .MAX_CHAINS (MAX_CHAINS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .in_ready   (in_ready),
    .emit_valid (emit_valid),
    .emit_ready (emit_ready),
    .emit_item  (emit_item),
    .mul_req    (mul_req),
    .mul_rsp    (mul_rsp),
    .div_req    (div_req),
    .div_rsp    (div_rsp)
  );

  tcd_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  tcd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while the previous item is in work");

  a_last_is_power: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last_of_run == (out_data.deriv_kind == KIND_POWER)))
    else $error("last_of_run and power result disagree");

  a_power_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.deriv_kind == KIND_POWER |-> out_data.deriv_index == 3'd0)
    else $error("power result with nonzero index");

  a_busy_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !emit_valid)
    else $error("result issued while idle");

endmodule

FILE: dv/tb_thermostat_chain_derivatives.sv
`timescale 1ns / 100ps

module tb_thermostat_chain_derivatives;
  import tcd_pkg::*;

  localparam int MAX_LINKS     = 8;
  localparam int SETTLE_CYCLES = 100;
  localparam int SINK_HOLD     = 300;
  localparam int RANDOM_LINKS  = 300;
  localparam int MAX_PRINTED   = 50;

  class chain_deriv_board;
    logic [47:0] target_q;
    logic [31:0] inv_tau2;
    logic [3:0]  link_count;
    logic [2:0]  excl_dofs;
    int unsigned link_pos;
    logic [47:0] held_ke;
    logic [63:0] held_dofs;
    longint      prev_z;
    longint      first_z;
    longint      pending_rate;
    out_item_t   pending_derivs[$];
    int          mismatches;
    int          noted;
    int          checked;
    int          kind_seen[3];

    function new();
      target_q     = 48'h1_0000;
      inv_tau2     = 32'h1_0000;
      link_count   = 4'd3;
      excl_dofs    = 3'd0;
      link_pos     = 0;
      held_ke      = '0;
      held_dofs    = 64'd1;
      prev_z       = 0;
      first_z      = 0;
      pending_rate = 0;
      mismatches   = 0;
      noted        = 0;
      checked      = 0;
      kind_seen    = '{0, 0, 0};
    endfunction

    task report_mismatch(string what);
      if (mismatches < MAX_PRINTED) $display("mismatch: %s", what);
      mismatches++;
    endtask

    function void set_reg(cfg_reg_t idx, logic [47:0] val);
      case (idx)
        REG_TARGET: target_q   = val;
        REG_TAU:    inv_tau2   = val[31:0];
        REG_COUNT:  link_count = val[3:0];
        REG_EXCL:   excl_dofs  = val[2:0];
        default: ;
      endcase
    endfunction

    function longint sat48(longint v);
      if (v > longint'(POS_MAX48)) return longint'(POS_MAX48);
      if (v < longint'(NEG_MIN48)) return longint'(NEG_MIN48);
      return v;
    endfunction

    function logic [63:0] mag(longint v);
      if (v < 0) return -v;
      return v;
    endfunction

    // exact product, magnitude truncated to q16, then saturated
    function longint scale_q16(logic [63:0] a, logic [63:0] b, bit neg);
      logic [127:0] p;
      p = ({64'd0, a} * {64'd0, b}) >> 16;
      if (p > 128'h7FFF_FFFF_FFFF) return neg ? longint'(NEG_MIN48) : longint'(POS_MAX48);
      return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function void add_deriv(longint v, logic [1:0] kind, int unsigned idx, bit last);
      out_item_t r;
      v = sat48(v);
      r.deriv_value = v[47:0];
      r.deriv_kind  = kind;
      r.deriv_index = idx[2:0];
      r.last_of_run = last;
      pending_derivs.push_back(r);
    endfunction

    function void note_link(in_item_t it);
      int unsigned m;
      longint      z;
      longint      nd;
      longint      d;
      longint      red;
      longint      t;
      logic [63:0] den;
      logic [63:0] ratio;
      logic [63:0] sq;
      logic [63:0] nk;
      noted++;
      m = link_count;
      if (m < 1) m = 1;
      if (m > MAX_LINKS) m = MAX_LINKS;
      if (link_pos >= m) link_pos = 0;
      z = longint'($signed(it.chain_value));
      if (link_pos == 0) begin
        nd = it.mobility_count;
        nd = nd - it.constraint_count - excl_dofs;
        if (nd < 1) nd = 1;
        held_dofs = nd;
        held_ke   = it.kinetic_energy;
        first_z   = z;
        den = held_dofs * target_q;
        ratio = (den == 0) ? 64'(RATIO_CAP) : {held_ke, 16'd0} / den;
        if (ratio > 64'(RATIO_CAP)) ratio = 64'(RATIO_CAP);
        d = longint'(ratio) - 65536;
        pending_rate = scale_q16(mag(d), {32'd0, inv_tau2}, d < 0);
      end else begin
        red = scale_q16(mag(prev_z), mag(z), (prev_z < 0) != (z < 0));
        sq  = mag(prev_z) * mag(prev_z);
        nk  = (link_pos == 1) ? held_dofs : 64'd1;
        add_deriv(pending_rate - red, KIND_CHAIN, link_pos - 1, 1'b0);
        add_deriv(prev_z, KIND_INTEGRAL, link_pos - 1, 1'b0);
        t = longint'((sq >> 16) * nk);
        pending_rate = sat48(t - longint'({32'd0, inv_tau2}));
      end
      if (link_pos == m - 1) begin
        add_deriv(pending_rate, KIND_CHAIN, link_pos, 1'b0);
        add_deriv(z, KIND_INTEGRAL, link_pos, 1'b0);
        add_deriv(scale_q16(mag(first_z) * 2, {16'd0, held_ke}, first_z > 0),
                  KIND_POWER, 0, 1'b1);
        link_pos = 0;
      end else begin
        link_pos++;
      end
      prev_z = z;
    endfunction

    task check_deriv(out_item_t got);
      out_item_t want;
      if (pending_derivs.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing expected", got));
        return;
      end
      want = pending_derivs.pop_front();
      checked++;
      if (want.deriv_kind < 3) kind_seen[want.deriv_kind]++;
      if (got.deriv_value !== want.deriv_value || got.deriv_kind !== want.deriv_kind ||
          got.deriv_index !== want.deriv_index || got.last_of_run !== want.last_of_run)
        report_mismatch($sformatf(
          "result %0d: got value %h kind %0d index %0d last %b, want %h %0d %0d %b",
          checked, got.deriv_value, got.deriv_kind, got.deriv_index, got.last_of_run,
          want.deriv_value, want.deriv_kind, want.deriv_index, want.last_of_run));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_we;
  cfg_reg_t    cfg_index;
  logic [47:0] cfg_data;

  chain_deriv_board board;
  int   burst_left;
  bit   steady_source;
  logic sink_hold_req;
  int   links_sent;
  int   settings_used;

  thermostat_chain_derivatives #(.MAX_CHAINS(MAX_LINKS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) board.note_link(in_data);
      if (out_valid && out_ready) board.check_deriv(out_data);
    end
  end

  // receiver: segments of random ready patterns, plus one long hold on request
  initial begin
    int seg;
    int mode;
    out_ready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(1, 40);
      repeat (seg) begin
        @(posedge clk);
        if (sink_hold_req) begin
          out_ready <= 1'b0;
          repeat (SINK_HOLD) @(posedge clk);
        end
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= 1'b0;
        endcase
      end
    end
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", board.pending_derivs.size());
    $display("== FAIL ==");
    $finish;
  end

  function automatic int eff_links(logic [3:0] c);
    if (c == 0) return 1;
    if (c > MAX_LINKS) return MAX_LINKS;
    return c;
  endfunction

  function automatic logic [31:0] rand_z();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0, 1: v = $urandom();
      2, 3: begin
        v = $urandom_range(0, 32'h0004_0000);
        if ($urandom_range(0, 1)) v = -v;
      end
      default: begin
        case ($urandom_range(0, 5))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'h0000_0000;
          3: v = 32'hFFFF_FFFF;
          4: v = 32'h0001_0000;
          default: v = 32'hFFFF_0000;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic in_item_t make_link(int pos);
    in_item_t    it;
    longint      n;
    logic [63:0] p;
    it.kinetic_energy   = 48'({$urandom(), $urandom()});
    it.mobility_count   = 12'($urandom());
    it.constraint_count = 12'($urandom());
    it.chain_value      = rand_z();
    if (pos == 0) begin
      if ($urandom_range(0, 2) != 0) it.constraint_count = 12'($urandom_range(0, 24));
      n = it.mobility_count;
      n = n - it.constraint_count - board.excl_dofs;
      if (n < 1) n = 1;
      case ($urandom_range(0, 4))
        0: begin
          p = board.target_q * n * $urandom_range(0, 3) + $urandom_range(0, 65535);
          it.kinetic_energy = p[47:0];
        end
        1: begin
          p = board.target_q * n;
          it.kinetic_energy = p[47:0];
        end
        2: it.kinetic_energy = $urandom_range(0, 1) ? '1 : '0;
        default: ;
      endcase
    end
    return it;
  endfunction

  task automatic offer_link(input in_item_t it);
    if (burst_left == 0) begin
      if (!steady_source && $urandom_range(0, 1)) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    links_sent++;
  endtask

  task automatic send_link(input logic [47:0] ke, input logic [11:0] mob,
                           input logic [11:0] con, input logic [31:0] z);
    in_item_t it;
    it.kinetic_energy   = ke;
    it.mobility_count   = mob;
    it.constraint_count = con;
    it.chain_value      = z;
    offer_link(it);
  endtask

  task automatic send_run(int count);
    for (int i = 0; i < count; i++) offer_link(make_link(i));
  endtask

  // wait for every expected result, then let a zero-result item finish
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (board.pending_derivs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [47:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_reg(idx, val);
    @(posedge clk);
  endtask

  initial begin
    int          phase;
    int          runs;
    int          m;
    int          stop_at;
    logic [47:0] tgt;
    logic [31:0] tau;
    logic [3:0]  cnt;
    board         = new();
    burst_left    = 0;
    steady_source = 1'b0;
    links_sent    = 0;
    settings_used = 1;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_data       <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_TARGET;
    cfg_data      <= '0;
    sink_hold_req <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults, ratio of two
    send_link(48'h0000_0006_0000, 12'd5, 12'd2, 32'h0001_0000);
    send_link(48'h0000_0000_0000, 12'd0, 12'd0, 32'hFFFE_0000);
    send_link(48'hFFFF_FFFF_FFFF, 12'hFFF, 12'hFFF, 32'h7FFF_FFFF);
    // field extremes, dof count clamped
    send_link(48'hFFFF_FFFF_FFFF, 12'd0, 12'hFFF, 32'h8000_0000);
    send_link(48'h0000_0000_0000, 12'hFFF, 12'd0, 32'h8000_0000);
    send_link(48'hFFFF_FFFF_FFFF, 12'hFFF, 12'hFFF, 32'h7FFF_FFFF);
    settle();
    write_reg(REG_COUNT, 48'd1);
    send_link(48'h0000_0000_0000, 12'hFFF, 12'd0, 32'hFFFF_FFFF);
    settle();
    // zero count acts as one link
    write_reg(REG_COUNT, 48'd0);
    send_link(48'h0000_0001_0000, 12'd1, 12'd0, 32'h0000_0001);
    settle();
    // zero target saturates the ratio, zero inverse time
    write_reg(REG_TARGET, 48'd0);
    write_reg(REG_TAU, 48'd0);
    send_link(48'h1234_5678_9ABC, 12'd10, 12'd3, 32'hFFFF_0000);
    settle();
    write_reg(REG_TARGET, 48'hFFFF_FFFF_FFFF);
    write_reg(REG_TAU, 48'h0000_FFFF_FFFF);
    write_reg(REG_COUNT, 48'd15);
    send_run(MAX_LINKS);
    settle();
    // count shrinks below the position mid run
    write_reg(REG_TARGET, 48'h1_0000);
    write_reg(REG_TAU, 48'h1_0000);
    write_reg(REG_COUNT, 48'd4);
    write_reg(REG_EXCL, 48'd7);
    send_run(3);
    settle();
    write_reg(REG_COUNT, 48'd2);
    send_run(2);
    settings_used += 6;

    stop_at = links_sent + RANDOM_LINKS;
    phase = 0;
    while (links_sent < stop_at) begin
      phase++;
      settle();
      case ($urandom_range(0, 5))
        0: tgt = 48'd1;
        1: tgt = 48'hFFFF_FFFF_FFFF;
        2: tgt = ($urandom_range(0, 3) == 0) ? 48'd0 : 48'h1_0000;
        3: tgt = 48'h1_0000;
        4: tgt = 48'($urandom_range(1, 20'hFFFFF));
        default: tgt = 48'({$urandom(), $urandom()});
      endcase
      case ($urandom_range(0, 5))
        0: tau = 32'd1;
        1: tau = 32'hFFFF_FFFF;
        2: tau = 32'd0;
        3: tau = 32'h1_0000;
        4: tau = $urandom_range(1, 32'h0004_0000);
        default: tau = $urandom();
      endcase
      case ($urandom_range(0, 9))
        8: cnt = 4'd0;
        9: cnt = 4'($urandom_range(9, 15));
        default: cnt = 4'($urandom_range(1, 8));
      endcase
      write_reg(REG_TARGET, tgt);
      write_reg(REG_TAU, {16'd0, tau});
      write_reg(REG_COUNT, {44'd0, cnt});
      write_reg(REG_EXCL, 48'($urandom_range(0, 7)));
      settings_used++;
      m = eff_links(board.link_count);
      steady_source = ($urandom_range(0, 3) == 0);
      if (phase == 2) begin
        // long receiver hold with back-to-back input
        steady_source = 1'b1;
        sink_hold_req <= 1'b1;
        @(posedge clk);
        sink_hold_req <= 1'b0;
        send_run(m);
        send_run(m);
      end
      runs = $urandom_range(1, 4);
      for (int r = 0; r < runs; r++) begin
        send_run(m);
        if ($urandom_range(0, 3) == 0) settle();
      end
      // partial run, next count write lands mid chain
      if (m > 1 && $urandom_range(0, 2) == 0) send_run($urandom_range(1, m - 1));
    end

    settle();
    if (board.pending_derivs.size() != 0)
      board.report_mismatch($sformatf("%0d expected results never arrived",
                                      board.pending_derivs.size()));
    $display("run covered %0d chain items over %0d register settings, counts 0..15",
             board.noted, settings_used);
    $display("checked %0d results: %0d chain rates, %0d integral rates, %0d power, %0d bad",
             board.checked, board.kind_seen[KIND_CHAIN], board.kind_seen[KIND_INTEGRAL],
             board.kind_seen[KIND_POWER], board.mismatches);
    if (board.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
